[rtl/core/hsd_pkg.sv]
// Shared constants, codes and interface structs of the Huffman stream decoder.
`default_nettype none
package hsd_pkg;

    localparam int SYMBOLS    = 256;
    localparam int MAX_NODES  = 511;
    localparam int COUNT_BITS = 32;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int NODES_W  = $clog2(MAX_NODES + 1);
    localparam int CHILD_W  = NODE_W + 1;
    localparam int DEPTH_W  = $clog2(SYMBOLS + 1);
    localparam int STACK_AW = $clog2(SYMBOLS);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_SYMBOL,
        PH_DATA,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_POP,
        ST_DINFO,
        ST_DCHILD,
        ST_DLEAF,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       leaf;
        logic [7:0] sym;
    } node_info_t;

    typedef struct packed {
        logic        left_done;
        logic [NODE_W-1:0] idx;
    } stack_entry_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        node_info_t        wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } info_req_t;

    typedef struct packed {
        logic               we;
        logic [CHILD_W-1:0] waddr;
        logic [NODE_W-1:0]  wdata;
        logic               re;
        logic [CHILD_W-1:0] raddr;
    } child_req_t;

    typedef struct packed {
        logic                we;
        logic [STACK_AW-1:0] waddr;
        stack_entry_t        wdata;
        logic                re;
        logic [STACK_AW-1:0] raddr;
    } stack_req_t;

    typedef struct packed {
        logic       push;
        logic       flush;
        logic [7:0] sym;
        logic       done;
        logic       err;
    } rb_ctrl_t;

    typedef struct packed {
        logic push_ok;
        logic flush_ok;
    } rb_stat_t;

endpackage
`default_nettype wire

[rtl/core/hsd_node_mem.sv]
// Node table: leaf flag and symbol per node, and child links per node and side.
`default_nettype none
module hsd_node_mem (
    input  wire                            aclk,
    input  hsd_pkg::info_req_t             info_req,
    output hsd_pkg::node_info_t            info_rdata,
    input  hsd_pkg::child_req_t            child_req,
    output logic [hsd_pkg::NODE_W-1:0]     child_rdata
);
    hsd_pkg::node_info_t        info_mem  [0:hsd_pkg::MAX_NODES-1];
    logic [hsd_pkg::NODE_W-1:0] child_mem [0:2*hsd_pkg::MAX_NODES-1];

    always_ff @(posedge aclk) begin
        if (info_req.we) begin
            info_mem[info_req.waddr] <= info_req.wdata;
        end
        if (info_req.re) begin
            info_rdata <= info_mem[info_req.raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (child_req.we) begin
            child_mem[child_req.waddr] <= child_req.wdata;
        end
        if (child_req.re) begin
            child_rdata <= child_mem[child_req.raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/hsd_stack_mem.sv]
// Parent stack storage: entries below the cached top of stack.
`default_nettype none
module hsd_stack_mem (
    input  wire                   aclk,
    input  hsd_pkg::stack_req_t   req,
    output hsd_pkg::stack_entry_t rdata
);
    hsd_pkg::stack_entry_t mem [0:hsd_pkg::SYMBOLS-1];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/hsd_result_buf.sv]
// Result buffer: holds one pending result until its last flag is known, plus the output slot.
`default_nettype none
module hsd_result_buf (
    input  wire               aclk,
    input  wire               aresetn,
    input  hsd_pkg::rb_ctrl_t ctrl,
    output hsd_pkg::rb_stat_t stat,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [7:0]        m_symbol,
    output logic              m_last_of_byte,
    output logic              m_stream_done,
    output logic              m_header_error
);
    logic       pend_v_reg, pend_v_next;
    logic [7:0] pend_sym_reg;
    logic       pend_done_reg;
    logic       pend_err_reg;
    logic       out_v_reg, out_v_next;
    logic       out_free;
    logic       move;

    assign out_free      = !out_v_reg || m_ready;
    assign stat.push_ok  = !pend_v_reg || out_free;
    assign stat.flush_ok = !pend_v_reg || out_free;
    assign move          = pend_v_reg && (ctrl.push || ctrl.flush);

    always_comb begin
        out_v_next  = out_v_reg && !m_ready;
        pend_v_next = pend_v_reg;
        if (move) begin
            out_v_next = 1'b1;
        end
        if (ctrl.push) begin
            pend_v_next = 1'b1;
        end else if (ctrl.flush) begin
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_symbol       <= pend_sym_reg;
            m_stream_done  <= pend_done_reg;
            m_header_error <= pend_err_reg;
            m_last_of_byte <= ctrl.flush;
        end
        if (ctrl.push) begin
            pend_sym_reg  <= ctrl.sym;
            pend_done_reg <= ctrl.done;
            pend_err_reg  <= ctrl.err;
        end
    end

    assign m_valid = out_v_reg;
endmodule
`default_nettype wire

[rtl/core/huffman_stream_decoder_top.sv]
// Top level of the Huffman stream decoder: bit sequencer around node and stack memories.
// Results pass through a pending slot and the output register; pushes wait for room.
// A byte is taken only in ST_IDLE and ends in ST_FLUSH; a header bit uses ST_BIT (plus
//   ST_POP when a completed parent is popped), a data bit ST_BIT and ST_DINFO, then for
//   an inner node ST_DCHILD, ST_DLEAF: dependent reads of info, child link, child info.
// Reset: synchronous active-low aresetn clears the state, phase, counters and count_reg;
//   the node and stack memories are left as they are and need no clearing pass.
`default_nettype none
module huffman_stream_decoder_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_code_byte,
    input  wire         s_restart,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_symbol,
    output logic        m_last_of_byte,
    output logic        m_stream_done,
    output logic        m_header_error
);
    localparam int NW  = hsd_pkg::NODE_W;
    localparam int NSW = hsd_pkg::NODES_W;
    localparam int DW  = hsd_pkg::DEPTH_W;
    localparam int SAW = hsd_pkg::STACK_AW;
    localparam int CB  = hsd_pkg::COUNT_BITS;

    hsd_pkg::state_t state_reg, state_next;
    hsd_pkg::phase_t phase_reg, phase_next;

    logic [7:0]     byte_reg, byte_next;
    logic [2:0]     bit_reg, bit_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [NW-1:0]  top_idx_reg, top_idx_next;
    logic           top_ldone_reg, top_ldone_next;
    logic [NSW-1:0] nodes_reg, nodes_next;
    logic [7:0]     shift_val_reg, shift_val_next;
    logic [2:0]     shift_cnt_reg, shift_cnt_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [NW-1:0]  nx_reg, nx_next;
    logic [CB-1:0]  emitted_reg, emitted_next;
    logic [CB-1:0]  count_reg, count_next;

    hsd_pkg::info_req_t    info_req;
    hsd_pkg::node_info_t   info_rdata;
    hsd_pkg::child_req_t   child_req;
    logic [NW-1:0]         child_rdata;
    hsd_pkg::stack_req_t   stack_req;
    hsd_pkg::stack_entry_t stack_rdata;
    hsd_pkg::rb_ctrl_t     rb_ctrl;
    hsd_pkg::rb_stat_t     rb_stat;

    // Helpers for the current bit step.
    logic          cur_bit;
    logic          last_bit;
    logic          table_full;
    logic          linked;
    logic          pop;
    logic [DW-1:0] depth_a;
    logic          stack_full;
    logic          count_hit;
    logic          done_flag;
    logic [7:0]    sym_val;
    logic          s_accept;

    assign cur_bit    = byte_reg[bit_reg];
    assign last_bit   = (bit_reg == 3'd7);
    assign table_full = (nodes_reg >= NSW'(hsd_pkg::MAX_NODES));
    assign linked     = (depth_reg != '0);
    assign pop        = linked && top_ldone_reg;
    assign depth_a    = pop ? depth_reg - DW'(1) : depth_reg;
    assign stack_full = (depth_a >= DW'(hsd_pkg::SYMBOLS));
    assign count_hit  = (emitted_reg >= count_reg);
    assign done_flag  = ((emitted_reg + CB'(1)) == count_reg);
    assign sym_val    = shift_val_reg | (8'(cur_bit) << shift_cnt_reg);

    assign s_ready   = (state_reg == hsd_pkg::ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hsd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = hsd_pkg::ST_BIT;
                end
            end
            hsd_pkg::ST_BIT: begin
                case (phase_reg)
                    hsd_pkg::PH_FLAG: begin
                        if (rb_stat.push_ok) begin
                            if (table_full || (!cur_bit && stack_full)) begin
                                state_next = hsd_pkg::ST_FLUSH;
                            end else if (cur_bit && pop && depth_a != '0) begin
                                state_next = hsd_pkg::ST_POP;
                            end else begin
                                state_next = last_bit ? hsd_pkg::ST_FLUSH : hsd_pkg::ST_BIT;
                            end
                        end
                    end
                    hsd_pkg::PH_SYMBOL: begin
                        if (shift_cnt_reg == 3'd7 && depth_reg == '0) begin
                            state_next = hsd_pkg::ST_FLUSH;
                        end else begin
                            state_next = last_bit ? hsd_pkg::ST_FLUSH : hsd_pkg::ST_BIT;
                        end
                    end
                    hsd_pkg::PH_DATA: begin
                        state_next = count_hit ? hsd_pkg::ST_FLUSH : hsd_pkg::ST_DINFO;
                    end
                    default: begin
                        state_next = hsd_pkg::ST_FLUSH;
                    end
                endcase
            end
            hsd_pkg::ST_POP: begin
                state_next = last_bit ? hsd_pkg::ST_FLUSH : hsd_pkg::ST_BIT;
            end
            hsd_pkg::ST_DINFO: begin
                if (!info_rdata.leaf) begin
                    state_next = hsd_pkg::ST_DCHILD;
                end else if (rb_stat.push_ok) begin
                    state_next = last_bit ? hsd_pkg::ST_FLUSH : hsd_pkg::ST_BIT;
                end
            end
            hsd_pkg::ST_DCHILD: begin
                state_next = hsd_pkg::ST_DLEAF;
            end
            hsd_pkg::ST_DLEAF: begin
                if (!info_rdata.leaf || rb_stat.push_ok) begin
                    state_next = last_bit ? hsd_pkg::ST_FLUSH : hsd_pkg::ST_BIT;
                end
            end
            hsd_pkg::ST_FLUSH: begin
                if (rb_stat.flush_ok) begin
                    state_next = hsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and result pushes.
    always_comb begin
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        depth_next     = depth_reg;
        top_idx_next   = top_idx_reg;
        top_ldone_next = top_ldone_reg;
        nodes_next     = nodes_reg;
        shift_val_next = shift_val_reg;
        shift_cnt_next = shift_cnt_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        emitted_next   = emitted_reg;
        count_next     = count_reg;
        info_req       = '0;
        child_req      = '0;
        stack_req      = '0;
        rb_ctrl        = '0;

        // Advance the bit index on every step back into ST_BIT.
        if (state_reg == hsd_pkg::ST_IDLE) begin
            bit_next = 3'd0;
        end else if (state_next == hsd_pkg::ST_BIT) begin
            bit_next = bit_reg + 3'd1;
        end else begin
            bit_next = bit_reg;
        end

        if (cfg_valid) begin
            count_next = CB'(cfg_data);
        end

        case (state_reg)
            hsd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    byte_next = s_code_byte;
                    if (s_restart) begin
                        phase_next     = hsd_pkg::PH_FLAG;
                        depth_next     = '0;
                        nodes_next     = '0;
                        shift_val_next = '0;
                        shift_cnt_next = '0;
                        cur_next       = '0;
                        emitted_next   = '0;
                    end
                end
            end
            hsd_pkg::ST_BIT: begin
                case (phase_reg)
                    hsd_pkg::PH_FLAG: begin
                        if (rb_stat.push_ok) begin
                            if (table_full) begin
                                rb_ctrl.push = 1'b1;
                                rb_ctrl.err  = 1'b1;
                                phase_next   = hsd_pkg::PH_HALT;
                            end else begin
                                // Write the new node and hang it under the top parent.
                                info_req.we         = 1'b1;
                                info_req.waddr      = nodes_reg[NW-1:0];
                                info_req.wdata.leaf = cur_bit;
                                info_req.wdata.sym  = 8'h00;
                                nodes_next          = nodes_reg + NSW'(1);
                                if (linked) begin
                                    child_req.we    = 1'b1;
                                    child_req.waddr = {top_idx_reg, top_ldone_reg};
                                    child_req.wdata = nodes_reg[NW-1:0];
                                    top_ldone_next  = 1'b1;
                                end
                                depth_next = depth_a;
                                if (cur_bit) begin
                                    phase_next     = hsd_pkg::PH_SYMBOL;
                                    shift_val_next = '0;
                                    shift_cnt_next = '0;
                                    if (pop && depth_a != '0) begin
                                        stack_req.re    = 1'b1;
                                        stack_req.raddr = SAW'(depth_a - DW'(1));
                                    end
                                end else if (stack_full) begin
                                    rb_ctrl.push = 1'b1;
                                    rb_ctrl.err  = 1'b1;
                                    phase_next   = hsd_pkg::PH_HALT;
                                end else begin
                                    // Spill the live top when it stays under the new one.
                                    if (!pop && linked) begin
                                        stack_req.we              = 1'b1;
                                        stack_req.waddr           = SAW'(depth_reg - DW'(1));
                                        stack_req.wdata.idx       = top_idx_reg;
                                        stack_req.wdata.left_done = 1'b1;
                                    end
                                    top_idx_next   = nodes_reg[NW-1:0];
                                    top_ldone_next = 1'b0;
                                    depth_next     = depth_a + DW'(1);
                                end
                            end
                        end
                    end
                    hsd_pkg::PH_SYMBOL: begin
                        if (shift_cnt_reg == 3'd7) begin
                            info_req.we         = 1'b1;
                            info_req.waddr      = NW'(nodes_reg - NSW'(1));
                            info_req.wdata.leaf = 1'b1;
                            info_req.wdata.sym  = sym_val;
                            shift_val_next      = '0;
                            shift_cnt_next      = '0;
                            if (depth_reg == '0) begin
                                phase_next = hsd_pkg::PH_DATA;
                                cur_next   = '0;
                            end else begin
                                phase_next = hsd_pkg::PH_FLAG;
                            end
                        end else begin
                            shift_val_next = sym_val;
                            shift_cnt_next = shift_cnt_reg + 3'd1;
                        end
                    end
                    hsd_pkg::PH_DATA: begin
                        if (!count_hit) begin
                            info_req.re    = 1'b1;
                            info_req.raddr = cur_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            hsd_pkg::ST_POP: begin
                top_idx_next   = stack_rdata.idx;
                top_ldone_next = stack_rdata.left_done;
            end
            hsd_pkg::ST_DINFO: begin
                if (!info_rdata.leaf) begin
                    child_req.re    = 1'b1;
                    child_req.raddr = {cur_reg, cur_bit};
                end else if (rb_stat.push_ok) begin
                    // Single-leaf tree: every bit emits the root symbol.
                    rb_ctrl.push = 1'b1;
                    rb_ctrl.sym  = info_rdata.sym;
                    rb_ctrl.done = done_flag;
                    emitted_next = emitted_reg + CB'(1);
                end
            end
            hsd_pkg::ST_DCHILD: begin
                nx_next        = child_rdata;
                info_req.re    = 1'b1;
                info_req.raddr = child_rdata;
            end
            hsd_pkg::ST_DLEAF: begin
                if (!info_rdata.leaf) begin
                    cur_next = nx_reg;
                end else if (rb_stat.push_ok) begin
                    rb_ctrl.push = 1'b1;
                    rb_ctrl.sym  = info_rdata.sym;
                    rb_ctrl.done = done_flag;
                    emitted_next = emitted_reg + CB'(1);
                    cur_next     = '0;
                end
            end
            hsd_pkg::ST_FLUSH: begin
                rb_ctrl.flush = rb_stat.flush_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hsd_pkg::ST_IDLE;
            phase_reg     <= hsd_pkg::PH_FLAG;
            depth_reg     <= '0;
            nodes_reg     <= '0;
            shift_val_reg <= '0;
            shift_cnt_reg <= '0;
            cur_reg       <= '0;
            emitted_reg   <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            depth_reg     <= depth_next;
            nodes_reg     <= nodes_next;
            shift_val_reg <= shift_val_next;
            shift_cnt_reg <= shift_cnt_next;
            cur_reg       <= cur_next;
            emitted_reg   <= emitted_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        bit_reg       <= bit_next;
        top_idx_reg   <= top_idx_next;
        top_ldone_reg <= top_ldone_next;
        nx_reg        <= nx_next;
    end

    hsd_node_mem u_node_mem (
        .aclk        (aclk),
        .info_req    (info_req),
        .info_rdata  (info_rdata),
        .child_req   (child_req),
        .child_rdata (child_rdata)
    );

    hsd_stack_mem u_stack_mem (
        .aclk  (aclk),
        .req   (stack_req),
        .rdata (stack_rdata)
    );

    hsd_result_buf u_result_buf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (rb_ctrl),
        .stat           (rb_stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_last_of_byte (m_last_of_byte),
        .m_stream_done  (m_stream_done),
        .m_header_error (m_header_error)
    );
endmodule
`default_nettype wire
